// ===== sv/lcpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the light cone point test block.
// No dependencies; imported by every module of the block.
package lcpt_pkg;

    localparam int COORD_BITS    = 20;
    localparam int COS_FRAC_BITS = 14;
    localparam int COS_BITS      = COS_FRAC_BITS + 2;
    localparam int RAD_BITS      = COORD_BITS - 1;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * DELTA_BITS;
    localparam int PROD_BITS     = DELTA_BITS + COS_BITS;
    localparam int DOT_BITS      = PROD_BITS + 2;
    localparam int IN_SQ_BITS    = 2 * RAD_BITS;
    // inside the radius |dot| < 2^RAD_BITS * 2^(COS_BITS-1) * sqrt(3)
    localparam int DMAG_BITS     = RAD_BITS + COS_BITS + 1;
    localparam int CMAG_BITS     = COS_FRAC_BITS + 1;
    localparam int M_BITS        = CMAG_BITS + RAD_BITS;
    localparam int C2_BITS       = 2 * COS_FRAC_BITS + 1;
    localparam int ROOT_BITS     = COS_FRAC_BITS + 1;
    localparam int BIT_IDX_BITS  = $clog2(ROOT_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 3 * COS_BITS;
    localparam int S_TDATA_BITS  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = 8;
    localparam int Q_DEPTH       = 8;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS    = Q_PTR_BITS + 1;
    localparam int FRONT_STAGES  = 4;
    localparam int INFL_BITS     = $clog2(FRONT_STAGES + 1);
    localparam int DM_LO         = DMAG_BITS / 2;
    localparam int DM_HI         = DMAG_BITS - DM_LO;
    localparam int D2_LO         = IN_SQ_BITS / 2;
    localparam int D2_HI         = IN_SQ_BITS - D2_LO;
    localparam int LHS_BITS      = C2_BITS + IN_SQ_BITS;
    localparam int RHS_BITS      = 2 * DMAG_BITS;
    localparam int CMP_BITS      = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

    localparam logic signed [COS_BITS-1:0] COS_ONE = COS_BITS'(1) <<< COS_FRAC_BITS;
    localparam logic signed [COS_BITS-1:0] COS_MINUS_ONE = -COS_ONE;
    localparam logic [C2_BITS-1:0] COS_ONE_SQ = C2_BITS'(1) << (2 * COS_FRAC_BITS);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OMNI   = 3'd0,
        REG_ORG_X  = 3'd1,
        REG_ORG_Y  = 3'd2,
        REG_ORG_Z  = 3'd3,
        REG_RADIUS = 3'd4,
        REG_AXIS   = 3'd5,
        REG_OUTER  = 3'd6,
        REG_ROT    = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOAD,
        CS_ROOT,
        CS_MUL
    } cone_state_t;

    typedef struct packed {
        logic                          omni;
        logic signed [COORD_BITS-1:0]  org_x;
        logic signed [COORD_BITS-1:0]  org_y;
        logic signed [COORD_BITS-1:0]  org_z;
        logic [RAD_BITS-1:0]           radius;
        logic signed [COS_BITS-1:0]    ax;
        logic signed [COS_BITS-1:0]    ay;
        logic signed [COS_BITS-1:0]    az;
        logic signed [COS_BITS-1:0]    cos_a;
        logic signed [COS_BITS-1:0]    cos_b;
        logic signed [COS_BITS-1:0]    cos_c;
        logic                          busy;
    } light_cfg_t;

    typedef struct packed {
        logic                  decided;
        logic                  dval;
        logic [DMAG_BITS-1:0]  dmag;
        logic [IN_SQ_BITS-1:0] dist2;
    } q_item_t;

    function automatic logic signed [COS_BITS-1:0] sat_cos(input logic [COS_BITS-1:0] v);
        logic signed [COS_BITS-1:0] s;
        s = $signed(v);
        if (s > COS_ONE) begin
            return COS_ONE;
        end else if (s < COS_MINUS_ONE) begin
            return COS_MINUS_ONE;
        end
        return s;
    endfunction

endpackage

// ===== sv/lcpt_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers and the cone cosine sequencer (bit-serial square roots).
// Depends on lcpt_pkg.
module lcpt_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [lcpt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lcpt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output lcpt_pkg::light_cfg_t              light
);
    import lcpt_pkg::*;

    logic                         omni_reg;
    logic [COORD_BITS-1:0]        org_x_reg, org_y_reg, org_z_reg;
    logic [RAD_BITS-1:0]          radius_reg;
    logic [3*COS_BITS-1:0]        axis_reg;
    logic [COS_BITS-1:0]          outer_reg, rot_reg;

    cone_state_t                  state_reg, state_next;
    logic [BIT_IDX_BITS-1:0]      bit_reg;
    logic [ROOT_BITS-1:0]         root0_reg, root1_reg;
    logic [C2_BITS-1:0]           va0_reg, va1_reg;
    logic signed [COS_BITS-1:0]   c_reg;

    logic                         start;
    logic signed [COS_BITS-1:0]   cos_a, cos_b;
    logic signed [2*COS_BITS-1:0] sq_a, sq_b, p_ab, x_sum, x_rnd, x_shift;
    logic [ROOT_BITS-1:0]         bit_mask, trial0, trial1;
    logic [2*ROOT_BITS-1:0]       t0_sq, t1_sq, p_s;

    assign start = cfg_valid && (cfg_reg_t'(cfg_index) == REG_OUTER ||
                                 cfg_reg_t'(cfg_index) == REG_ROT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omni_reg   <= 1'b0;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            org_z_reg  <= '0;
            radius_reg <= '0;
            axis_reg   <= '0;
            outer_reg  <= COS_ONE;
            rot_reg    <= COS_ONE;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_OMNI:   omni_reg   <= cfg_data[0];
                REG_ORG_X:  org_x_reg  <= cfg_data[COORD_BITS-1:0];
                REG_ORG_Y:  org_y_reg  <= cfg_data[COORD_BITS-1:0];
                REG_ORG_Z:  org_z_reg  <= cfg_data[COORD_BITS-1:0];
                REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
                REG_AXIS:   axis_reg   <= cfg_data[3*COS_BITS-1:0];
                REG_OUTER:  outer_reg  <= cfg_data[COS_BITS-1:0];
                REG_ROT:    rot_reg    <= cfg_data[COS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cos_a    = sat_cos(outer_reg);
        cos_b    = sat_cos(rot_reg);
        sq_a     = cos_a * cos_a;
        sq_b     = cos_b * cos_b;
        bit_mask = ROOT_BITS'(1) << bit_reg;
        trial0   = root0_reg | bit_mask;
        trial1   = root1_reg | bit_mask;
        t0_sq    = trial0 * trial0;
        t1_sq    = trial1 * trial1;
        p_ab     = cos_a * cos_b;
        p_s      = root0_reg * root1_reg;
        x_sum    = p_ab - $signed({{(2*COS_BITS-2*ROOT_BITS){1'b0}}, p_s});
        x_rnd    = x_sum + $signed((2*COS_BITS)'(1) << (COS_FRAC_BITS - 1));
        x_shift  = x_rnd >>> COS_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: state_next = start ? CS_LOAD : CS_IDLE;
            CS_LOAD: state_next = start ? CS_LOAD : CS_ROOT;
            CS_ROOT: begin
                if (start) begin
                    state_next = CS_LOAD;
                end else if (bit_reg == '0) begin
                    state_next = CS_MUL;
                end
            end
            CS_MUL:  state_next = start ? CS_LOAD : CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    // sqrt(1 - a*a) and sqrt(1 - b*b), one result bit per cycle, MSB first, then cos_c from them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg <= COS_ONE;
        end else begin
            case (state_reg)
                CS_LOAD: begin
                    va0_reg   <= COS_ONE_SQ - sq_a[C2_BITS-1:0];
                    va1_reg   <= COS_ONE_SQ - sq_b[C2_BITS-1:0];
                    root0_reg <= '0;
                    root1_reg <= '0;
                    bit_reg   <= BIT_IDX_BITS'(ROOT_BITS - 1);
                end
                CS_ROOT: begin
                    if (t0_sq <= {1'b0, va0_reg}) root0_reg <= trial0;
                    if (t1_sq <= {1'b0, va1_reg}) root1_reg <= trial1;
                    bit_reg <= bit_reg - 1'b1;
                end
                CS_MUL:  c_reg <= x_shift[COS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        light.omni   = omni_reg;
        light.org_x  = $signed(org_x_reg);
        light.org_y  = $signed(org_y_reg);
        light.org_z  = $signed(org_z_reg);
        light.radius = radius_reg;
        light.ax     = $signed(axis_reg[COS_BITS-1:0]);
        light.ay     = $signed(axis_reg[2*COS_BITS-1:COS_BITS]);
        light.az     = $signed(axis_reg[3*COS_BITS-1:2*COS_BITS]);
        light.cos_a  = cos_a;
        light.cos_b  = cos_b;
        light.cos_c  = c_reg;
        light.busy   = (state_reg != CS_IDLE) || start;
    end

endmodule

// ===== sv/lcpt_front.sv =====
`timescale 1ns / 1ps
// Front pipeline: accepts points, forms distance and dot product, classifies.
// Depends on lcpt_pkg.
module lcpt_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lcpt_pkg::light_cfg_t            light,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcpt_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  logic [lcpt_pkg::Q_CNT_BITS-1:0]  q_count,
    output logic                            push,
    output lcpt_pkg::q_item_t               item,
    output logic [lcpt_pkg::C2_BITS-1:0]     c2
);
    import lcpt_pkg::*;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DELTA_BITS-1:0]  dx_reg, dy_reg, dz_reg;
    logic [SQ_BITS-1:0]            sx_reg, sy_reg, sz_reg;
    logic signed [PROD_BITS-1:0]   px_reg, py_reg, pz_reg;
    logic [SQ_BITS-1:0]            dist2_reg;
    logic signed [DOT_BITS-1:0]    dot_reg;
    q_item_t                       item_reg;

    logic [IN_SQ_BITS-1:0]         r2_reg;
    logic [M_BITS-1:0]             m_reg;
    logic [C2_BITS-1:0]            c2_reg;
    logic                          all_reg, lin_reg;

    logic signed [COS_BITS-1:0]    c_eff;
    logic [CMAG_BITS-1:0]          c_mag;
    logic signed [2*COS_BITS-1:0]  c_sq;
    logic signed [COS_BITS:0]      neg_a;
    logic signed [SQ_BITS-1:0]     sqx, sqy, sqz;
    logic [INFL_BITS:0]            inflight;
    logic [Q_CNT_BITS:0]           used;
    logic                          accept;
    logic                          far, dneg, lin_ok;
    logic [DOT_BITS-1:0]           dabs;
    logic [DMAG_BITS-1:0]          dmag;

    assign inflight = (INFL_BITS+1)'(v1_reg) + (INFL_BITS+1)'(v2_reg) +
                      (INFL_BITS+1)'(v3_reg) + (INFL_BITS+1)'(v4_reg);
    assign used     = (Q_CNT_BITS+1)'(q_count) + (Q_CNT_BITS+1)'(inflight);
    assign s_tready = !light.busy && (used < (Q_CNT_BITS+1)'(Q_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // light-wide terms, refreshed every cycle from the registers
    always_comb begin
        c_eff = (light.cos_b == COS_ONE) ? light.cos_a : light.cos_c;
        c_sq  = c_eff * c_eff;
        c_mag = c_eff[COS_BITS-1] ? CMAG_BITS'(-c_eff) : c_eff[CMAG_BITS-1:0];
        neg_a = -$signed({light.cos_a[COS_BITS-1], light.cos_a});
    end

    always_ff @(posedge aclk) begin
        r2_reg  <= light.radius * light.radius;
        m_reg   <= c_mag * light.radius;
        c2_reg  <= c_sq[C2_BITS-1:0];
        all_reg <= light.omni || ($signed({light.cos_b[COS_BITS-1], light.cos_b}) <= neg_a);
        lin_reg <= (light.cos_b != COS_ONE) && (light.cos_c <= 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb begin
        sqx = dx_reg * dx_reg;
        sqy = dy_reg * dy_reg;
        sqz = dz_reg * dz_reg;
    end

    always_comb begin
        far    = dist2_reg >= SQ_BITS'(r2_reg);
        dneg   = dot_reg[DOT_BITS-1];
        dabs   = dneg ? DOT_BITS'(-dot_reg) : DOT_BITS'(dot_reg);
        dmag   = dabs[DMAG_BITS-1:0];
        lin_ok = dneg ? (dmag >= DMAG_BITS'(m_reg)) : (dmag == '0 && m_reg == '0);
    end

    always_ff @(posedge aclk) begin
        // delta = origin - point
        dx_reg <= DELTA_BITS'(light.org_x) - DELTA_BITS'($signed(s_tdata[COORD_BITS-1:0]));
        dy_reg <= DELTA_BITS'(light.org_y) -
                  DELTA_BITS'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
        dz_reg <= DELTA_BITS'(light.org_z) -
                  DELTA_BITS'($signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]));

        sx_reg <= sqx;
        sy_reg <= sqy;
        sz_reg <= sqz;
        px_reg <= dx_reg * light.ax;
        py_reg <= dy_reg * light.ay;
        pz_reg <= dz_reg * light.az;

        dist2_reg <= sx_reg + sy_reg + sz_reg;
        dot_reg   <= DOT_BITS'(px_reg) + DOT_BITS'(py_reg) + DOT_BITS'(pz_reg);

        item_reg.decided <= far || all_reg || lin_reg || dneg || (dmag == '0);
        item_reg.dval    <= !far && (all_reg || (lin_reg && lin_ok));
        item_reg.dmag    <= dmag;
        item_reg.dist2   <= dist2_reg[IN_SQ_BITS-1:0];
    end

    assign push = v4_reg;
    assign item = item_reg;
    assign c2   = c2_reg;

endmodule

// ===== sv/lcpt_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back pipelines, registered read.
// Depends on lcpt_pkg.
module lcpt_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  lcpt_pkg::q_item_t               wr_item,
    input  logic                            pop,
    output lcpt_pkg::q_item_t               rd_item,
    output logic [lcpt_pkg::Q_CNT_BITS-1:0]  count
);
    import lcpt_pkg::*;

    q_item_t                mem [Q_DEPTH];
    q_item_t                rd_item_reg;
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // popped entry lands in the read register in the cycle after the pop
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_item_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
        end
    end

    assign rd_item = rd_item_reg;
    assign count   = count_reg;

endmodule

// ===== sv/lcpt_back.sv =====
`timescale 1ns / 1ps
// Back pipeline: squared cone compare in partial products, output register.
// Depends on lcpt_pkg.
module lcpt_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lcpt_pkg::q_item_t               item,
    input  logic [lcpt_pkg::Q_CNT_BITS-1:0]  q_count,
    input  logic [lcpt_pkg::C2_BITS-1:0]     c2,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcpt_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import lcpt_pkg::*;

    logic                       ce;
    logic                       r_valid_reg;
    logic                       b1_valid_reg, b2_valid_reg, m_valid_reg;
    logic                       b1_dec_reg, b1_dval_reg, b2_dec_reg, b2_dval_reg;
    logic [2*DM_HI-1:0]         hh_reg;
    logic [DM_HI+DM_LO-1:0]     hl_reg;
    logic [2*DM_LO-1:0]         ll_reg;
    logic [C2_BITS+D2_HI-1:0]   ph_reg;
    logic [C2_BITS+D2_LO-1:0]   pl_reg;
    logic [CMP_BITS-1:0]        lhs_reg, rhs_reg;
    logic                       affects_reg;

    assign ce  = !m_valid_reg || m_tready;
    assign pop = ce && (q_count != '0);

    // r_valid_reg marks the queue read register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg  <= 1'b0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (ce) begin
            r_valid_reg  <= pop;
            b1_valid_reg <= r_valid_reg;
            b2_valid_reg <= b1_valid_reg;
            m_valid_reg  <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hh_reg <= item.dmag[DMAG_BITS-1:DM_LO] * item.dmag[DMAG_BITS-1:DM_LO];
            hl_reg <= item.dmag[DMAG_BITS-1:DM_LO] * item.dmag[DM_LO-1:0];
            ll_reg <= item.dmag[DM_LO-1:0] * item.dmag[DM_LO-1:0];
            ph_reg <= c2 * item.dist2[IN_SQ_BITS-1:D2_LO];
            pl_reg <= c2 * item.dist2[D2_LO-1:0];
            b1_dec_reg  <= item.decided;
            b1_dval_reg <= item.dval;

            // c^2 * dist2 against dot^2
            lhs_reg <= (CMP_BITS'(ph_reg) << D2_LO) + CMP_BITS'(pl_reg);
            rhs_reg <= (CMP_BITS'(hh_reg) << (2 * DM_LO)) +
                       (CMP_BITS'(hl_reg) << (DM_LO + 1)) + CMP_BITS'(ll_reg);
            b2_dec_reg  <= b1_dec_reg;
            b2_dval_reg <= b1_dval_reg;

            affects_reg <= b2_dec_reg ? b2_dval_reg : (lhs_reg <= rhs_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(affects_reg);

endmodule

// ===== sv/light_cone_point_test_core.sv =====
`timescale 1ns / 1ps
// Light cone point test: one point per cycle while the output is not stalled and no
// cone cosine update is running.
// The result path runs through the 4-stage front pipeline, the queue write and read registers
// and 3 back stages.
// A write to outer_cosine or rotation_limit starts the cone cosine computation
// (bit-serial roots); s_tready stays low meanwhile.
// aresetn is synchronous, active low; registers return to their reset values.
module light_cone_point_test_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x [19:0], point_y [39:20], point_z [59:40], zero fill above
    input  logic [lcpt_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // affects [0], zero fill above
    output logic [lcpt_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcpt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lcpt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import lcpt_pkg::*;

    light_cfg_t             light;
    q_item_t                f_item, q_item;
    logic                   push, pop;
    logic [Q_CNT_BITS-1:0]  q_count;
    logic [C2_BITS-1:0]     c2;

    assign cfg_ready = 1'b1;

    lcpt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .light     (light)
    );

    lcpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .light    (light),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_count  (q_count),
        .push     (push),
        .item     (f_item),
        .c2       (c2)
    );

    lcpt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (f_item),
        .pop     (pop),
        .rd_item (q_item),
        .count   (q_count)
    );

    lcpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (q_item),
        .q_count  (q_count),
        .c2       (c2),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/lcpt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for light_cone_point_test_core, attached by bind.
// Depends on lcpt_pkg.
module lcpt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lcpt_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [lcpt_pkg::CFG_IDX_BITS-1:0]  cfg_index
);
    import lcpt_pkg::*;

    // reset empties the output stage
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // a cone register write holds off input right after it is taken
    a_cone_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready &&
         (cfg_index == REG_OUTER || cfg_index == REG_ROT)) |=> !s_tready)
        else $error("input taken during cone cosine update");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // only bit 0 of the result carries data
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_BITS-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind light_cone_point_test_core lcpt_checker u_lcpt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

// ===== sim/light_cone_point_test_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for light_cone_point_test_core: point streams against omni and spot lights.
// Depends on lcpt_pkg and the core; a local predictor checks every result in order.
module light_cone_point_test_core_tb;
    import lcpt_pkg::*;

    localparam int    LIMIT_CYCLES = 400000;
    localparam longint COORD_MAX   = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) << (COORD_BITS - 1));
    localparam longint ONE         = longint'(1) << COS_FRAC_BITS;

    typedef struct {
        logic                         omni;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [COORD_BITS-1:0] oz;
        logic [RAD_BITS-1:0]          rad;
        logic [3*COS_BITS-1:0]        axis;
        logic [COS_BITS-1:0]          outer;
        logic [COS_BITS-1:0]          rot;
    } light_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    light_t light;
    bit     reach_q[$];
    int     mismatches = 0;
    int     points_sent = 0;
    int     points_lit = 0;
    int     settings_used = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    longint cycles = 0;

    light_cone_point_test_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("light_cone_point_test_core test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (reach_q.size() == 0) begin
                report_mismatch("unexpected result", -1, m_tdata[0]);
            end else begin
                bit exp_reach;
                exp_reach = reach_q.pop_front();
                if (m_tdata[0] !== exp_reach) begin
                    report_mismatch("affects", exp_reach, m_tdata[0]);
                end
            end
        end
    end

    // -------- predictor --------
    function automatic longint clamp_cosine(input logic [COS_BITS-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint floor_root(input longint v);
        longint r;
        r = 0;
        for (int b = COS_FRAC_BITS; b >= 0; b--) begin
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v) begin
                r = r | (longint'(1) << b);
            end
        end
        return r;
    endfunction

    // cos(acos a + acos b), rounded to the cosine grid
    function automatic longint summed_angle_cos(input longint a, input longint b);
        longint s0, s1, x;
        s0 = floor_root(ONE * ONE - a * a);
        s1 = floor_root(ONE * ONE - b * b);
        x = a * b - s0 * s1;
        return (x + (ONE >>> 1)) >>> COS_FRAC_BITS;
    endfunction

    function automatic bit light_reaches(input light_t L, input logic signed [COORD_BITS-1:0] px,
                                         input logic signed [COORD_BITS-1:0] py,
                                         input logic signed [COORD_BITS-1:0] pz);
        longint d[3];
        longint dist2, dot, dmag, r, a, b, c, m;
        logic [127:0] lhs, rhs;
        d[0] = longint'(L.ox) - longint'(px);
        d[1] = longint'(L.oy) - longint'(py);
        d[2] = longint'(L.oz) - longint'(pz);
        dist2 = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            dist2 += d[i] * d[i];
            dot += d[i] * longint'($signed(L.axis[i*COS_BITS +: COS_BITS]));
        end
        r = longint'(L.rad);
        if (dist2 >= r * r) return 0;
        a = clamp_cosine(L.outer);
        b = clamp_cosine(L.rot);
        if (L.omni || b <= -a) return 1;
        dmag = (dot < 0) ? -dot : dot;
        if (b == ONE) begin
            c = a;
        end else begin
            c = summed_angle_cos(a, b);
            if (c <= 0) begin
                m = -c * r;
                if (dot < 0) return dmag >= m;
                return dmag == 0 && m == 0;
            end
        end
        if (dot <= 0) return 0;
        lhs = c * c;
        lhs = lhs * dist2;
        rhs = dmag;
        rhs = rhs * rhs;
        return lhs <= rhs;
    endfunction

    // -------- drivers --------
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_OMNI:   light.omni = value[0];
            REG_ORG_X:  light.ox = value[COORD_BITS-1:0];
            REG_ORG_Y:  light.oy = value[COORD_BITS-1:0];
            REG_ORG_Z:  light.oz = value[COORD_BITS-1:0];
            REG_RADIUS: light.rad = value[RAD_BITS-1:0];
            REG_AXIS:   light.axis = value;
            REG_OUTER:  light.outer = value[COS_BITS-1:0];
            REG_ROT:    light.rot = value[COS_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic logic [COORD_BITS-1:0] clip(input longint v);
        if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
        if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
        return COORD_BITS'(v);
    endfunction

    // called at a falling edge; returns at a falling edge with s_tvalid possibly still high
    task automatic send_point(input longint x, input longint y, input longint z);
        logic signed [COORD_BITS-1:0] px, py, pz;
        px = clip(x);
        py = clip(y);
        pz = clip(z);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {{(S_TDATA_BITS - 3*COORD_BITS){1'b0}}, pz, py, px};
        do @(posedge aclk); while (!s_tready);
        reach_q.push_back(light_reaches(light, px, py, pz));
        points_sent++;
        points_lit += reach_q[$];
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        wait (reach_q.size() == 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_light(input bit omni, input longint ox, input longint oy, input longint oz,
                             input longint rad, input logic [3*COS_BITS-1:0] axis,
                             input logic [COS_BITS-1:0] outer, input logic [COS_BITS-1:0] rot);
        drain();
        write_reg(REG_OMNI, omni);
        write_reg(REG_ORG_X, CFG_DATA_BITS'(ox));
        write_reg(REG_ORG_Y, CFG_DATA_BITS'(oy));
        write_reg(REG_ORG_Z, CFG_DATA_BITS'(oz));
        write_reg(REG_RADIUS, CFG_DATA_BITS'(rad));
        write_reg(REG_AXIS, axis);
        write_reg(REG_OUTER, outer);
        write_reg(REG_ROT, rot);
        settings_used++;
    endtask

    function automatic logic [3*COS_BITS-1:0] axis_of(input longint x, input longint y,
                                                      input longint z);
        return {COS_BITS'(z), COS_BITS'(y), COS_BITS'(x)};
    endfunction

    // -------- tests --------
    task automatic test_reset_light();
        // zero radius after reset: nothing is lit
        send_point(0, 0, 0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    endtask

    task automatic test_omni_sphere();
        set_light(1, 0, 0, 0, COORD_MAX, '0, COS_BITS'(ONE), COS_BITS'(ONE));
        send_point(0, 0, 0);
        send_point(-COORD_MAX, 0, 0);          // on the sphere: rejected
        send_point(-COORD_MAX + 1, 0, 0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, 5, -5);
    endtask

    task automatic test_spot_outer_only();
        set_light(0, 1000, -2000, 3000, 100000, axis_of(ONE, 0, 0), COS_BITS'(11585),
                  COS_BITS'(ONE));
        send_point(1000 - 50000, -2000, 3000);
        send_point(1000 + 50000, -2000, 3000);
        send_point(1000 - 30000, -2000 + 29000, 3000);
        send_point(1000 - 30000, -2000 + 31000, 3000);
        send_point(1000, -2000, 3000);         // zero dot
    endtask

    task automatic test_rotation_limit();
        // wide cone sum: non-positive cosine, linear test
        set_light(0, 0, 0, 0, 50000, axis_of(0, 0, -32768), COS_BITS'(11585), COS_BITS'(0));
        send_point(0, 0, -20000);
        send_point(0, 0, 20000);
        send_point(30000, 0, 100);
        send_point(0, 0, 0);
        // rotation limit at minus outer: whole sphere
        set_light(0, 0, 0, 0, 50000, axis_of(ONE, ONE, ONE), COS_BITS'(11585),
                  COS_BITS'(-11585));
        send_point(40000, 0, 0);
        send_point(-40000, 0, 0);
        // out of range cosines saturate
        set_light(0, 0, 0, 0, COORD_MAX, axis_of(-32768, 32767, -1), 16'h7fff, 16'h8000);
        send_point(COORD_MAX, 0, 0);
        send_point(100, -100, 7);
        set_light(0, -7, 9, 11, COORD_MAX, axis_of(ONE, 0, 0), 16'h8000, 16'h7fff);
        send_point(-7 - 1000, 9, 11);
        send_point(-7 + 1000, 9, 11);
    endtask

    task automatic test_random_lights();
        int n_settings, mode;
        n_settings = 15;
        for (int k = 0; k < n_settings; k++) begin
            longint ox, oy, oz, rad, ax, ay, az, t, q;
            logic [3*COS_BITS-1:0] axis;
            logic [COS_BITS-1:0] outer, rot;
            mode = k * 3 / n_settings;
            send_idle = (mode == 0) ? 17 : (mode == 1) ? 69 : 0;
            recv_idle = (mode == 0) ? 69 : (mode == 1) ? 17 : 0;
            ox = longint'($signed(COORD_BITS'($urandom)));
            oy = longint'($signed(COORD_BITS'($urandom)));
            oz = longint'($signed(COORD_BITS'($urandom)));
            case ($urandom_range(3))
                0: rad = COORD_MAX;
                1: rad = $urandom_range(0, 64);
                default: rad = $urandom_range(1, COORD_MAX);
            endcase
            ax = $urandom_range(0, 2 * ONE) - ONE;
            ay = $urandom_range(0, 2 * ONE) - ONE;
            az = $urandom_range(0, 2 * ONE) - ONE;
            axis = ($urandom_range(4) == 0) ? {$urandom, $urandom} : axis_of(ax, ay, az);
            outer = ($urandom_range(5) == 0) ? COS_BITS'($urandom)
                                            : COS_BITS'($urandom_range(0, 2 * ONE) - ONE);
            case ($urandom_range(5))
                0, 1: rot = COS_BITS'(ONE);
                2: rot = COS_BITS'($urandom);
                default: rot = COS_BITS'($urandom_range(0, 2 * ONE) - ONE);
            endcase
            set_light($urandom_range(4) == 0, ox, oy, oz, rad, axis, outer, rot);
            ax = longint'($signed(axis[0 +: COS_BITS]));
            ay = longint'($signed(axis[COS_BITS +: COS_BITS]));
            az = longint'($signed(axis[2*COS_BITS +: COS_BITS]));
            q = rad / 2 + 1;
            for (int i = 0; i < 28; i++) begin
                case ($urandom_range(9))
                    0, 1: send_point(longint'($signed(COORD_BITS'($urandom))),
                                     longint'($signed(COORD_BITS'($urandom))),
                                     longint'($signed(COORD_BITS'($urandom))));
                    2, 3, 4, 5: begin
                        // along the axis, into the lit side, with jitter
                        t = $urandom_range(0, q);
                        send_point(ox - (t * ax) / ONE +
                                   longint'($urandom_range(0, 2 * q / 4)) - q / 4,
                                   oy - (t * ay) / ONE +
                                   longint'($urandom_range(0, 2 * q / 4)) - q / 4,
                                   oz - (t * az) / ONE +
                                   longint'($urandom_range(0, 2 * q / 4)) - q / 4);
                    end
                    default: send_point(ox + $urandom_range(0, 2 * q) - q,
                                        oy + $urandom_range(0, 2 * q) - q,
                                        oz + $urandom_range(0, 2 * q) - q);
                endcase
            end
        end
    endtask

    initial begin
        light = '{omni: 0, ox: 0, oy: 0, oz: 0, rad: 0, axis: 0,
                  outer: COS_BITS'(ONE), rot: COS_BITS'(ONE)};
        send_idle = 17;
        recv_idle = 69;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        test_reset_light();
        test_omni_sphere();
        test_spot_outer_only();
        test_rotation_limit();
        test_random_lights();
        drain();
        if (reach_q.size() != 0) begin
            report_mismatch("results still owed", reach_q.size(), 0);
        end
        $display("covered %0d points over %0d light settings, %0d lit, %0d mismatches",
                 points_sent, settings_used, points_lit, mismatches);
        if (mismatches == 0) begin
            $display("light_cone_point_test_core test passed");
        end else begin
            $display("light_cone_point_test_core test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lcpt_pkg.sv
sv/lcpt_cfg.sv
sv/lcpt_front.sv
sv/lcpt_queue.sv
sv/lcpt_back.sv
sv/light_cone_point_test_core.sv
sv/lcpt_checker.sv
sim/light_cone_point_test_core_tb.sv
